/* src/csfg_pkg.sv */
// Package for the composite sync filler generator.
// Widths, timing constants, register indexes and shared types; no dependencies.
package csfg_pkg;

  localparam int unsigned FracW    = 32;
  localparam int unsigned HalfW    = 11;
  localparam int unsigned CursorW  = HalfW + FracW;
  localparam int unsigned StepW    = 24;
  localparam int unsigned CountW   = 16;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned LoadW    = 33;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  // half-line counts
  localparam logic [HalfW-1:0] NtscField = 11'd525;
  localparam logic [HalfW-1:0] PalField  = 11'd625;
  localparam logic [HalfW-1:0] NtscFrame = 11'd1050;
  localparam logic [HalfW-1:0] PalFrame  = 11'd1250;
  localparam logic [HalfW-1:0] NtscEq    = 11'd6;
  localparam logic [HalfW-1:0] PalEq     = 11'd5;

  localparam logic [LevelW-1:0] LevelBlack = 8'd19;
  localparam logic [LevelW-1:0] LevelSync  = 8'd0;

  localparam logic [StepW-1:0]  StepReset   = 24'd8388608;
  localparam logic [CountW-1:0] BlkLenReset = 16'd1024;

  typedef enum logic {
    OpEmit = 1'b0,
    OpLoad = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStandard   = 3'd0,
    CfgStep       = 3'd1,
    CfgEqWidth    = 3'd2,
    CfgBroadWidth = 3'd3,
    CfgHsyncWidth = 3'd4,
    CfgBlockLen   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [FracW-1:0] equalizing;
    logic [FracW-1:0] broad;
    logic [FracW-1:0] hsync;
  } pulse_widths_t;

endpackage

/* src/csfg_if.sv */
// Valid/ready channel interfaces for the composite sync filler generator.
// Depends on csfg_pkg.
interface csfg_in_if import csfg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [LoadW-1:0] load_position;

  modport source (output valid, output op, output load_position, input ready);
  modport sink   (input valid, input op, input load_position, output ready);
endinterface

interface csfg_out_if import csfg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] video_level;
  logic              block_end;

  modport source (output valid, output video_level, output block_end, input ready);
  modport sink   (input valid, input video_level, input block_end, output ready);
endinterface

/* src/csfg_level.sv */
// Sync decode: picks the pulse width for a half-line and compares the fraction.
// Depends on csfg_pkg.
module csfg_level import csfg_pkg::*; (
  input  logic             ntsc_i,
  input  logic [HalfW-1:0] half_i,
  input  logic [FracW-1:0] frac_i,
  input  pulse_widths_t    widths_i,
  output logic             sync_o
);

  logic [HalfW-1:0] field;
  logic [HalfW-1:0] eq1;
  logic [HalfW-1:0] eq2;
  logic [HalfW-1:0] eq3;
  logic [HalfW-1:0] local1;
  logic [HalfW-1:0] local2;
  logic [FracW-1:0] width;

  always_comb begin
    field = ntsc_i ? NtscField : PalField;
    eq1   = ntsc_i ? NtscEq : PalEq;
    eq2   = eq1 << 1;
    eq3   = eq2 + eq1;
    // cursor stays below 1250 half-lines, so two conditional subtracts reduce it
    local1 = (half_i >= field) ? half_i - field : half_i;
    local2 = (local1 >= field) ? local1 - field : local1;

    if (local2 < eq1 || (local2 >= eq2 && local2 < eq3)) begin
      width = widths_i.equalizing;
    end else if (local2 < eq2) begin
      width = widths_i.broad;
    end else if (!half_i[0]) begin
      width = widths_i.hsync;
    end else begin
      width = '0;
    end
    sync_o = frac_i < width;
  end

endmodule

/* src/composite_sync_filler_generator.sv */
// Composite sync filler generator: black-level PAL/NTSC video with sync pulses.
// Depends on csfg_pkg, csfg_in_if / csfg_out_if and csfg_level.
//
// Usage:
//   in_i carries items: op = emit produces one sample, op = load sets the
//   frame cursor to load_position (half-line index above bit 31, Q32
//   fraction below) and produces nothing.
//   out_o carries samples: video_level (0 sync tip, 19 black) and block_end,
//   set on the last sample of every block_length samples (0 acts as 1).
//   The config port (cfg_we_i, cfg_index_i, cfg_data_i) writes one register
//   per cycle; write it only while the block is idle.
// Timing:
//   One item per clock while out_o is not stalled. A sample appears on out_o
//   the cycle after its emit transfer, set by the single output register that
//   follows the sync decode of the current 43-bit cursor.
// Reset:
//   rst_ni clears the cursor, the block count and the output valid, and
//   loads register defaults (PAL, step 1/512 half-line, block length 1024).
// Stall:
//   While out_o holds a sample that is not taken, in_i.ready is low; the
//   sample and all state hold. in_i.ready is high whenever the output
//   register is empty or being drained in that cycle.
module composite_sync_filler_generator import csfg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  csfg_in_if.sink             in_i,
  csfg_out_if.source          out_o
);

  // configuration registers
  logic               ntsc_q;
  logic [StepW-1:0]   step_q;
  pulse_widths_t      widths_q;
  logic [CountW-1:0]  blk_len_q;

  // state
  logic [CursorW-1:0] cursor_q, cursor_d;
  logic [CountW-1:0]  count_q, count_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [LevelW-1:0]  level_q, level_d;
  logic               blk_end_q, blk_end_d;

  logic               in_xfer;
  logic               emit;
  logic               sync;
  logic [CursorW-1:0] frame;
  logic [CursorW-1:0] sum;
  logic [CountW-1:0]  len;
  logic [CountW:0]    cnt_inc;
  logic               last;

  // ---------------------------------------------------------------------------
  // Config writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ntsc_q    <= 1'b0;
      step_q    <= StepReset;
      widths_q  <= '0;
      blk_len_q <= BlkLenReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgStandard:   ntsc_q            <= cfg_data_i[0];
        CfgStep:       step_q            <= cfg_data_i[StepW-1:0];
        CfgEqWidth:    widths_q.equalizing <= cfg_data_i[FracW-1:0];
        CfgBroadWidth: widths_q.broad    <= cfg_data_i[FracW-1:0];
        CfgHsyncWidth: widths_q.hsync    <= cfg_data_i[FracW-1:0];
        CfgBlockLen:   blk_len_q         <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;
  assign emit       = in_xfer && (op_e'(in_i.op) == OpEmit);

  // ---------------------------------------------------------------------------
  // Sync decode from the current cursor
  // ---------------------------------------------------------------------------
  csfg_level u_level (
    .ntsc_i   (ntsc_q),
    .half_i   (cursor_q[CursorW-1:FracW]),
    .frac_i   (cursor_q[FracW-1:0]),
    .widths_i (widths_q),
    .sync_o   (sync)
  );

  // ---------------------------------------------------------------------------
  // Cursor advance and wrap. A loaded value is below two half-lines, so it
  // never needs reducing. After a standard change the cursor can sit past
  // the new frame; one subtract after the next advance brings it back.
  // ---------------------------------------------------------------------------
  always_comb begin
    frame = {(ntsc_q ? NtscFrame : PalFrame), {FracW{1'b0}}};
    sum   = cursor_q + {{(CursorW-StepW){1'b0}}, step_q};

    cursor_d = cursor_q;
    if (in_xfer) begin
      if (op_e'(in_i.op) == OpLoad) begin
        cursor_d = {{(CursorW-LoadW){1'b0}}, in_i.load_position};
      end else begin
        cursor_d = (sum >= frame) ? sum - frame : sum;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Block counter; a lowered block length ends the block at once
  // ---------------------------------------------------------------------------
  always_comb begin
    len     = (blk_len_q == '0) ? CountW'(1) : blk_len_q;
    cnt_inc = {1'b0, count_q} + (CountW+1)'(1);
    last    = cnt_inc >= {1'b0, len};
    count_d = count_q;
    if (emit) begin
      count_d = last ? '0 : cnt_inc[CountW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    level_d     = level_q;
    blk_end_d   = blk_end_q;
    if (emit) begin
      out_valid_d = 1'b1;
      level_d     = sync ? LevelSync : LevelBlack;
      blk_end_d   = last;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    level_q   <= level_d;
    blk_end_q <= blk_end_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.video_level = level_q;
  assign out_o.block_end   = blk_end_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cursor_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q[CursorW-1:FracW] < PalFrame)
    else $error("frame cursor past the largest frame");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(emit))
    else $error("sample shown without an emit transfer");

  a_load_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && op_e'(in_i.op) == OpLoad) |=> $stable(count_q))
    else $error("cursor load moved the block count");

  a_level_codes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (level_q == LevelSync || level_q == LevelBlack))
    else $error("sample level is neither sync nor black");

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for composite_sync_filler_generator.
// Drives item transfers and register writes, predicts each sample and checks
// every output transfer. Depends on csfg_pkg, csfg_if.sv and the RTL top.
module tb_top import csfg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Timing constants kept apart from the package so a wrong RTL constant shows.
  localparam logic [HalfW-1:0]  FieldHalvesNtsc = 11'd525;
  localparam logic [HalfW-1:0]  FieldHalvesPal  = 11'd625;
  localparam logic [HalfW-1:0]  FrameHalvesNtsc = 11'd1050;
  localparam logic [HalfW-1:0]  FrameHalvesPal  = 11'd1250;
  localparam logic [HalfW-1:0]  EqHalvesNtsc    = 11'd6;
  localparam logic [HalfW-1:0]  EqHalvesPal     = 11'd5;
  localparam logic [LevelW-1:0] Black           = 8'd19;
  localparam logic [LevelW-1:0] SyncTip         = 8'd0;
  localparam int unsigned       RandomItems     = 100;   // per idling phase

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic              last;
  } sample_t;

  // One row of the directed table: either an item transfer or a register write.
  typedef enum logic { RowItem, RowReg } row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    op_e                 op;
    logic [LoadW-1:0]    pos;
    cfg_idx_e            reg_idx;
    logic [CfgDataW-1:0] data;
    logic                known;   // level/last typed in by hand
    logic [LevelW-1:0]   level;
    logic                last;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgDataW-1:0] cfg_data;
  cfg_idx_e            cfg_index;

  csfg_in_if  in_if ();
  csfg_out_if out_if ();

  composite_sync_filler_generator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: register shadow copies and the generator's own state.
  // Values match the block's reset defaults.
  // ---------------------------------------------------------------------------
  logic               cfg_ntsc    = 1'b0;
  logic [StepW-1:0]   cfg_step    = 24'd8388608;
  logic [FracW-1:0]   cfg_eq_w    = '0;
  logic [FracW-1:0]   cfg_broad_w = '0;
  logic [FracW-1:0]   cfg_hsync_w = '0;
  logic [CountW-1:0]  cfg_blk_len = 16'd1024;
  logic [CursorW-1:0] cur_pos     = '0;   // half-line above bit 31, Q32 fraction below
  logic [CountW-1:0]  samples_in_block = '0;

  sample_t expected_samples[$];   // predicted samples not yet seen on out_o

  int send_idle_pct   = 0;   // chance in 100 that the sender idles a cycle
  int stall_pct       = 0;   // chance in 100 that the receiver stalls a cycle
  int hold_left       = 0;   // long receiver hold-off, counted down by the receiver
  int failures        = 0;
  int samples_checked = 0;
  int sync_tips       = 0;
  int block_ends      = 0;
  int loads_sent      = 0;

  stim_row_t directed[$];

  // Sync tip when the fraction sits below the pulse width of this half-line.
  // Within a field: equalizing, broad, equalizing, then hsync on even halves only.
  function automatic logic [LevelW-1:0] sample_level(logic [CursorW-1:0] pos);
    logic [HalfW-1:0] half;
    logic [HalfW-1:0] in_field;
    logic [HalfW-1:0] eq_n;
    logic [FracW-1:0] pulse_w;
    half     = pos[CursorW-1:FracW];
    in_field = half % (cfg_ntsc ? FieldHalvesNtsc : FieldHalvesPal);
    eq_n     = cfg_ntsc ? EqHalvesNtsc : EqHalvesPal;
    if (in_field < eq_n || (in_field >= 2 * eq_n && in_field < 3 * eq_n)) pulse_w = cfg_eq_w;
    else if (in_field < 2 * eq_n) pulse_w = cfg_broad_w;
    else if (!half[0]) pulse_w = cfg_hsync_w;
    else pulse_w = '0;
    return (pos[FracW-1:0] < pulse_w) ? SyncTip : Black;
  endfunction

  // Applies one accepted item to the predictor; returns 1 when it yields a sample.
  function automatic bit run_generator(op_e op, logic [LoadW-1:0] pos, output sample_t s);
    logic [CursorW:0] frame;
    logic [CursorW:0] next;
    logic [CountW:0]  len;
    frame = {1'b0, (cfg_ntsc ? FrameHalvesNtsc : FrameHalvesPal), {FracW{1'b0}}};
    s = '0;
    if (op == OpLoad) begin
      next    = {{(CursorW + 1 - LoadW){1'b0}}, pos} % frame;
      cur_pos = next[CursorW-1:0];
      return 1'b0;
    end
    s.level = sample_level(cur_pos);
    // zero block length behaves as one; a lowered length ends the block at once
    len     = (cfg_blk_len == '0) ? 17'd1 : {1'b0, cfg_blk_len};
    s.last  = ({1'b0, samples_in_block} + 17'd1 >= len);
    samples_in_block = s.last ? '0 : samples_in_block + 1'b1;
    // one subtraction is enough even after a PAL->NTSC switch mid-frame
    next = {1'b0, cur_pos} + {{(CursorW + 1 - StepW){1'b0}}, cfg_step};
    if (next >= frame) next = next - frame;
    cur_pos = next[CursorW-1:0];
    return 1'b1;
  endfunction

  function automatic stim_row_t item_row(op_e op, logic [LoadW-1:0] pos);
    stim_row_t r;
    r      = '0;
    r.kind = RowItem;
    r.op   = op;
    r.pos  = pos;
    return r;
  endfunction

  function automatic stim_row_t known_row(op_e op, logic [LoadW-1:0] pos,
                                          logic [LevelW-1:0] lvl, logic lst);
    stim_row_t r;
    r       = item_row(op, pos);
    r.known = 1'b1;
    r.level = lvl;
    r.last  = lst;
    return r;
  endfunction

  function automatic stim_row_t reg_row(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    stim_row_t r;
    r         = '0;
    r.kind    = RowReg;
    r.reg_idx = idx;
    r.data    = data;
    return r;
  endfunction

  function automatic logic [LoadW-1:0] rand_position();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[LoadW-1:0];
  endfunction

  // Mostly random widths, with the zero and all-ones extremes mixed in.
  function automatic logic [FracW-1:0] rand_width();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [CountW-1:0] rand_blk_len();
    case ($urandom_range(5))
      0:       return '1;
      1:       return CountW'($urandom());
      default: return CountW'($urandom_range(9, 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Called at a falling edge; returns at the falling edge after the
  // transfer. valid is left high so back-to-back items never toggle it twice
  // in one step; settle() lowers it.
  // ---------------------------------------------------------------------------
  task automatic send_item(op_e op, logic [LoadW-1:0] pos, bit known = 1'b0,
                           logic [LevelW-1:0] lvl = '0, logic lst = 1'b0);
    sample_t s;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.op            <= op;
    in_if.load_position <= pos;
    do @(posedge clk_i); while (!in_if.ready);
    if (run_generator(op, pos, s)) begin
      if (known) begin
        s.level = lvl;
        s.last  = lst;
      end
      expected_samples.push_back(s);
    end else begin
      loads_sent++;
    end
    @(negedge clk_i);
  endtask

  // Stop offering, wait for every predicted sample, then cover the latency of a
  // trailing load before touching any register.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
    case (idx)
      CfgStandard:   cfg_ntsc    = data[0];
      CfgStep:       cfg_step    = data[StepW-1:0];
      CfgEqWidth:    cfg_eq_w    = data;
      CfgBroadWidth: cfg_broad_w = data;
      CfgHsyncWidth: cfg_hsync_w = data;
      CfgBlockLen:   cfg_blk_len = data[CountW-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic ntsc, logic [StepW-1:0] stp, logic [FracW-1:0] eq_w,
                           logic [FracW-1:0] broad_w, logic [FracW-1:0] hs_w,
                           logic [CountW-1:0] len);
    write_reg(CfgStandard,   CfgDataW'(ntsc));
    write_reg(CfgStep,       CfgDataW'(stp));
    write_reg(CfgEqWidth,    eq_w);
    write_reg(CfgBroadWidth, broad_w);
    write_reg(CfgHsyncWidth, hs_w);
    write_reg(CfgBlockLen,   CfgDataW'(len));
  endtask

  // Roughly one load in ten; emits carry random garbage in load_position.
  task automatic random_items(int unsigned n);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_item(OpLoad, rand_position());
      else send_item(OpEmit, rand_position());
    end
  endtask

  task automatic emit_until_half(int unsigned target);
    while (cur_pos[CursorW-1:FracW] < target) send_item(OpEmit, rand_position());
  endtask

  // ---------------------------------------------------------------------------
  // Clock, receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls per phase, plus a long hold-off when requested.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every output transfer is matched against the oldest predicted sample.
  always @(posedge clk_i) begin
    sample_t want;
    if (out_if.valid && out_if.ready) begin
      if (expected_samples.size() == 0) begin
        $error("video_level: unexpected sample, got %0d", out_if.video_level);
        failures++;
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_if.video_level == SyncTip) sync_tips++;
        if (out_if.block_end) block_ends++;
        if (out_if.video_level !== want.level) begin
          $error("video_level: expected %0d, got %0d", want.level, out_if.video_level);
          failures++;
        end
        if (out_if.block_end !== want.last) begin
          $error("block_end: expected %0d, got %0d", want.last, out_if.block_end);
          failures++;
        end
      end
    end
  end

  // Watchdog: a run that never finishes ends with a mismatch.
  initial begin
    #100_000;
    $display("composite_sync_filler_generator: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    logic [FracW-1:0] eq_keep;
    logic [FracW-1:0] broad_keep;
    logic [FracW-1:0] hs_keep;
    logic [CountW-1:0] len_keep;

    in_if.valid         = 1'b0;
    in_if.op            = OpEmit;
    in_if.load_position = '0;
    cfg_we              = 1'b0;
    cfg_index           = CfgStandard;
    cfg_data            = '0;
    rst_ni              = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table. Typed expectations only where the answer is obvious:
    // reset defaults give black, zero block length marks every sample,
    // full-width pulses give sync except at the largest fraction.
    directed.push_back(known_row(OpEmit, '0, Black, 1'b0));            // straight out of reset
    directed.push_back(reg_row(CfgBlockLen, 32'd0));                   // zero length acts as one
    directed.push_back(known_row(OpEmit, '1, Black, 1'b1));            // emit ignores load_position
    directed.push_back(reg_row(CfgEqWidth, 32'hFFFF_FFFF));
    directed.push_back(item_row(OpLoad, 33'h0_0000_0000));
    directed.push_back(known_row(OpEmit, '0, SyncTip, 1'b1));
    directed.push_back(item_row(OpLoad, 33'h0_FFFF_FFFF));             // largest fraction
    directed.push_back(known_row(OpEmit, '0, Black, 1'b1));
    directed.push_back(item_row(OpLoad, 33'h1_FFFF_FFFF));             // largest load value
    directed.push_back(known_row(OpEmit, '0, Black, 1'b1));
    directed.push_back(reg_row(CfgStandard, 32'd1));
    directed.push_back(item_row(OpLoad, 33'h1_0000_0000));
    directed.push_back(known_row(OpEmit, '0, SyncTip, 1'b1));
    directed.push_back(reg_row(CfgBlockLen, 32'h0000_FFFF));
    directed.push_back(reg_row(CfgStep, 32'd0));                       // cursor stands still
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(item_row(OpLoad, 33'h0_8000_0000));             // load keeps the block count
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(reg_row(CfgBlockLen, 32'd2));                   // now below the count
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(reg_row(CfgStep, 32'h00FF_FFFF));
    directed.push_back(reg_row(CfgEqWidth, 32'd0));                    // fraction 0 not below 0
    directed.push_back(reg_row(CfgBroadWidth, 32'hFFFF_FFFF));
    directed.push_back(reg_row(CfgHsyncWidth, 32'h8000_0000));
    directed.push_back(item_row(OpLoad, 33'h0_0000_0000));
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(item_row(OpEmit, '0));
    directed.push_back(item_row(OpEmit, '0));

    foreach (directed[i]) begin
      if (directed[i].kind == RowReg) begin
        settle();
        write_reg(directed[i].reg_idx, directed[i].data);
      end else begin
        send_item(directed[i].op, directed[i].pos, directed[i].known,
                  directed[i].level, directed[i].last);
      end
    end

    // Random part, one idling mode per phase.
    // No idling, every register at its top value.
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(1'b1, '1, '1, '1, '1, '1);
    random_items(RandomItems);

    // Sender mostly idle, registers at their low end (widths still random).
    settle();
    send_idle_pct = 67;
    stall_pct     = 0;
    configure(1'b0, '0, rand_width(), rand_width(), rand_width(), 16'd1);
    random_items(RandomItems);

    // Receiver mostly stalling.
    settle();
    send_idle_pct = 0;
    stall_pct     = 67;
    configure(1'($urandom_range(1)), StepW'($urandom()), rand_width(), rand_width(),
              rand_width(), rand_blk_len());
    random_items(RandomItems);

    // Both sides idling now and then.
    settle();
    send_idle_pct = 29;
    stall_pct     = 29;
    configure(1'($urandom_range(1)), StepW'($urandom()), rand_width(), rand_width(),
              rand_width(), rand_blk_len());
    random_items(RandomItems);

    // Back-pressure: receiver holds off for a long stretch while the sender
    // keeps offering, so the output register fills and the input stalls.
    settle();
    send_idle_pct = 0;
    stall_pct     = 0;
    configure(1'($urandom_range(1)), StepW'($urandom()), rand_width(), rand_width(),
              rand_width(), rand_blk_len());
    hold_left = 200;
    random_items(60);

    // Short sweep at the largest step (about 1/256 half-line per sample).
    // Loads only reach half-lines 0 and 1, so start at the end of half-line 1
    // and step on into the first PAL broad pulse at half-line 5.
    settle();
    eq_keep    = rand_width();
    broad_keep = rand_width();
    hs_keep    = rand_width();
    len_keep   = rand_blk_len();
    configure(1'b0, '1, eq_keep, broad_keep, hs_keep, len_keep);
    send_item(OpLoad, 33'h1_FFFF_FF00);
    emit_until_half(5);
    repeat (64) send_item(OpEmit, rand_position());

    settle();
    repeat (5) @(negedge clk_i);

    $display("Run covered %0d samples (%0d sync tips, %0d block ends) and %0d cursor loads,",
             samples_checked, sync_tips, block_ends, loads_sent);
    $display("over four idling modes, a long receiver hold-off and a sweep into broad sync.");
    if (failures == 0) begin
      $display("composite_sync_filler_generator: match");
    end else begin
      $display("composite_sync_filler_generator: mismatch");
    end
    $finish;
  end

endmodule
